// ===== hdl/pdt_pkg.sv =====
// Shared types and constants for the paired device table.
package pdt_pkg;

    localparam int MaxDevices = 8;
    localparam int IdxW       = $clog2(MaxDevices);
    localparam int CntW       = $clog2(MaxDevices + 1);

    typedef enum logic [3:0] {
        ACT_TOUCH     = 4'd0,
        ACT_ADD       = 4'd1,
        ACT_REMOVE    = 4'd2,
        ACT_CLEAR     = 4'd3,
        ACT_READ      = 4'd4,
        ACT_FIND      = 4'd5,
        ACT_RECONNECT = 4'd6,
        ACT_CANDIDATE = 4'd7,
        ACT_WINDOW    = 4'd8
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [47:0] dev_addr;
        logic [31:0] paired_at;
        logic [31:0] last_seen;
        logic [15:0] vendor;
        logic [15:0] product;
        logic [15:0] descriptor_len;
        logic [7:0]  proto_mode;
        logic        reconnect;
    } entry_t;

    // Write command broadcast from the controller to every cell.
    typedef struct packed {
        logic          wr_en;
        logic [IdxW-1:0] wr_slot;
        logic          full_wr;
        logic          flag_wr;
        entry_t        data;
        logic          shift;
    } cell_cmd_t;

endpackage

// ===== hdl/pdt_cell.sv =====
// One table slot; in scan mode it hands its record to the neighbor below.
module pdt_cell
(
    input  logic                 clk,
    input  pdt_pkg::cell_cmd_t   cmd,
    input  logic [pdt_pkg::IdxW-1:0] slot,
    input  pdt_pkg::entry_t      prev_entry,
    output pdt_pkg::entry_t      entry
);
    import pdt_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.shift)
        begin
            entry_next = prev_entry;
        end
        else if (cmd.wr_en && cmd.wr_slot == slot)
        begin
            if (cmd.full_wr)
            begin
                entry_next = cmd.data;
            end
            else if (cmd.flag_wr)
            begin
                entry_next.reconnect = cmd.data.reconnect;
            end
            else
            begin
                entry_next.last_seen      = cmd.data.last_seen;
                entry_next.vendor         = cmd.data.vendor;
                entry_next.product        = cmd.data.product;
                entry_next.descriptor_len = cmd.data.descriptor_len;
                entry_next.proto_mode     = cmd.data.proto_mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== hdl/paired_device_table.sv =====
// Top level: controller over a rotating chain of table cells.
// Scan actions rotate the cell chain once, one slot per cycle, and then present
// the result; other actions skip the rotation. One item is handled at a time:
// a new item is taken only after the previous result has been accepted.
// Reset: rst_n clears the count, window register and control; records are
// undefined until written.
module paired_device_table
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[3:0], dev_addr[51:4], entry_index[54:52], time_ms[86:55],
    // vendor_num[102:87], product_num[118:103], descriptor_len[134:119],
    // proto_mode[142:135], allow_reconnect[143]
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // ok[0], found_slot[3:1], out_dev_addr[51:4], out_paired_at[83:52],
    // out_last_seen[115:84], out_vendor[131:116], out_product[147:132],
    // out_descriptor_len[163:148], out_proto_mode[171:164],
    // out_reconnect[172], entry_count[176:173], zero[183:177]
    output logic [183:0] m_tdata
);
    import pdt_pkg::*;

    state_t state_reg, state_next;
    logic [31:0] window_reg;
    logic [CntW-1:0] count_reg, count_next;
    logic [143:0] in_reg;
    logic [IdxW-1:0] step_reg, step_next;
    logic hit_reg, hit_next;
    logic [IdxW-1:0] hit_slot_reg, hit_slot_next;
    logic best_ok_reg, best_ok_next;
    logic [IdxW-1:0] best_slot_reg, best_slot_next;
    entry_t best_reg, best_next;
    entry_t rd_reg, rd_next;
    logic [183:0] out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    entry_t cells [MaxDevices];
    cell_cmd_t cmd;

    logic [3:0]  in_action;
    logic [47:0] in_id;
    logic [2:0]  in_idx;
    logic [31:0] in_time;
    assign in_action = in_reg[3:0];
    assign in_id     = in_reg[51:4];
    assign in_idx    = in_reg[54:52];
    assign in_time   = in_reg[86:55];

    genvar g;
    generate
        for (g = 0; g < MaxDevices; g++)
        begin : g_cell
            pdt_cell u_cell
            (
                .clk        (clk),
                .cmd        (cmd),
                .slot       (IdxW'(g)),
                .prev_entry (cells[(g + 1) % MaxDevices]),
                .entry      (cells[g])
            );
        end
    endgenerate

    logic scan_act;
    logic step_valid;
    entry_t head;
    assign scan_act = in_action inside {ACT_TOUCH, ACT_FIND, ACT_RECONNECT, ACT_CANDIDATE};
    // cell at rotation head holds slot step_reg after step_reg shifts
    assign head = cells[0];
    assign step_valid = {1'b0, step_reg} < count_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!scan_act || step_reg == IdxW'(MaxDevices - 1))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_valid_reg && m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        logic ok;
        logic [IdxW-1:0] s;
        logic [IdxW-1:0] last;
        logic [31:0] age;
        entry_t e;
        cmd = '0;
        count_next = count_reg;
        step_next = step_reg;
        hit_next = hit_reg;
        hit_slot_next = hit_slot_reg;
        best_ok_next = best_ok_reg;
        best_slot_next = best_slot_reg;
        best_next = best_reg;
        rd_next = rd_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        ok = 1'b0;
        s = '0;
        last = IdxW'(count_reg - 1'b1);
        age = '0;
        e = '0;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                hit_next = 1'b0;
                hit_slot_next = '0;
                best_ok_next = 1'b0;
                best_slot_next = '0;
            end
            ST_SCAN:
            begin
                if (scan_act)
                begin
                    // rotate: slot step_reg sits at the first cell before shift
                    cmd.shift = 1'b1;
                    step_next = step_reg + 1'b1;
                end
                else
                begin
                    rd_next = cells[in_idx];
                    if (in_action == ACT_WINDOW && count_reg != '0)
                    begin
                        rd_next.paired_at = cells[last].paired_at;
                    end
                end
            end
            ST_APPLY:
            begin
                out_next = '0;
                e = '0;
                case (in_action)
                    ACT_TOUCH:
                    begin
                        if (hit_reg)
                        begin
                            ok = 1'b1;
                            s = hit_slot_reg;
                        end
                        else if (count_reg < CntW'(MaxDevices))
                        begin
                            ok = 1'b1;
                            s = count_reg[IdxW-1:0];
                            count_next = count_reg + 1'b1;
                            cmd.full_wr = 1'b1;
                        end
                        cmd.wr_en = ok;
                        cmd.wr_slot = s;
                        cmd.data.dev_addr = in_id;
                        cmd.data.paired_at = in_time;
                        cmd.data.last_seen = in_time;
                        cmd.data.vendor = in_reg[102:87];
                        cmd.data.product = in_reg[118:103];
                        cmd.data.descriptor_len = in_reg[134:119];
                        cmd.data.proto_mode = in_reg[142:135];
                        cmd.data.reconnect = 1'b1;
                    end
                    ACT_ADD:
                    begin
                        if (count_reg < CntW'(MaxDevices))
                        begin
                            ok = 1'b1;
                            count_next = count_reg + 1'b1;
                            cmd.wr_en = 1'b1;
                            cmd.full_wr = 1'b1;
                            cmd.wr_slot = count_reg[IdxW-1:0];
                            cmd.data.dev_addr = in_id;
                            cmd.data.paired_at = in_time;
                            cmd.data.last_seen = in_time;
                            cmd.data.reconnect = 1'b1;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (count_reg != '0)
                        begin
                            ok = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        ok = 1'b1;
                        count_next = '0;
                    end
                    ACT_READ:
                    begin
                        if ({1'b0, in_idx} < count_reg)
                        begin
                            ok = 1'b1;
                            e = rd_reg;
                        end
                    end
                    ACT_FIND:
                    begin
                        ok = hit_reg;
                        out_next[3:1] = hit_reg ? hit_slot_reg : 3'd0;
                    end
                    ACT_RECONNECT:
                    begin
                        ok = hit_reg;
                        cmd.wr_en = hit_reg;
                        cmd.flag_wr = 1'b1;
                        cmd.wr_slot = hit_slot_reg;
                        cmd.data.reconnect = in_reg[143];
                    end
                    ACT_CANDIDATE:
                    begin
                        ok = best_ok_reg;
                        if (best_ok_reg)
                        begin
                            e = best_reg;
                        end
                    end
                    ACT_WINDOW:
                    begin
                        age = in_time - rd_reg.paired_at;
                        ok = count_reg != '0 && age <= window_reg;
                    end
                    default: ok = 1'b0;
                endcase
                out_next[0] = ok;
                out_next[51:4] = e.dev_addr;
                out_next[83:52] = e.paired_at;
                out_next[115:84] = e.last_seen;
                out_next[131:116] = e.vendor;
                out_next[147:132] = e.product;
                out_next[163:148] = e.descriptor_len;
                out_next[171:164] = e.proto_mode;
                out_next[172] = e.reconnect;
                out_next[176:173] = 4'(count_next);
                out_valid_next = 1'b1;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    out_valid_next = 1'b0;
                end
            end
            default: out_valid_next = 1'b0;
        endcase
        // scan compare on the record at the head cell
        if (state_reg == ST_SCAN && scan_act && step_valid)
        begin
            if (!hit_reg && head.dev_addr == in_id)
            begin
                hit_next = 1'b1;
                hit_slot_next = step_reg;
            end
            if (head.reconnect && (!best_ok_reg || head.last_seen > best_reg.last_seen))
            begin
                best_ok_next = 1'b1;
                best_slot_next = step_reg;
                best_next = head;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            window_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                window_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg <= s_tdata;
        end
        step_reg <= step_next;
        hit_reg <= hit_next;
        hit_slot_reg <= hit_slot_next;
        best_ok_reg <= best_ok_next;
        best_slot_reg <= best_slot_next;
        best_reg <= best_next;
        rd_reg <= rd_next;
        out_reg <= out_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== sim/pdt_checker.sv =====
// Checker for the paired device table: predicts each result and compares it.
module pdt_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [183:0] m_tdata,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pdt_pkg::*;

    typedef struct packed {
        logic        ok;
        logic [2:0]  found_slot;
        entry_t      rec;
        logic [3:0]  count;
    } table_result_t;

    entry_t        slots[MaxDevices];
    int            used;
    logic [31:0]   window_val;
    table_result_t awaited[$];

    assign pending = awaited.size();

    function automatic int locate(logic [47:0] id);
        for (int i = 0; i < used; i++)
            if (slots[i].dev_addr == id)
                return i;
        return -1;
    endfunction

    task automatic apply_item(logic [143:0] d);
        action_t       act;
        logic [47:0]   id;
        logic [2:0]    idx;
        logic [31:0]   t;
        int            s;
        table_result_t r;
        act = action_t'(d[3:0]);
        id  = d[51:4];
        idx = d[54:52];
        t   = d[86:55];
        r   = '0;
        case (act)
            ACT_TOUCH, ACT_ADD:
            begin
                s = (act == ACT_TOUCH) ? locate(id) : -1;
                if (s < 0 && used < MaxDevices)
                begin
                    s = used;
                    used++;
                    slots[s] = '0;
                    slots[s].dev_addr = id;
                    slots[s].paired_at = t;
                    slots[s].last_seen = t;
                    slots[s].reconnect = 1'b1;
                end
                else if (act == ACT_ADD)
                    s = -1;
                if (s >= 0)
                begin
                    r.ok = 1'b1;
                    if (act == ACT_TOUCH)
                    begin
                        slots[s].last_seen      = t;
                        slots[s].vendor         = d[102:87];
                        slots[s].product        = d[118:103];
                        slots[s].descriptor_len = d[134:119];
                        slots[s].proto_mode     = d[142:135];
                    end
                end
            end
            ACT_REMOVE:
                if (used > 0)
                begin
                    used--;
                    r.ok = 1'b1;
                end
            ACT_CLEAR:
            begin
                used = 0;
                r.ok = 1'b1;
            end
            ACT_READ:
                if (idx < used)
                begin
                    r.ok  = 1'b1;
                    r.rec = slots[idx];
                end
            ACT_FIND, ACT_RECONNECT:
            begin
                s = locate(id);
                if (s >= 0)
                begin
                    r.ok = 1'b1;
                    if (act == ACT_FIND)
                        r.found_slot = s[2:0];
                    else
                        slots[s].reconnect = d[143];
                end
            end
            ACT_CANDIDATE:
            begin
                s = -1;
                for (int i = 0; i < used; i++)
                    if (slots[i].reconnect && (s < 0 || slots[i].last_seen > slots[s].last_seen))
                        s = i;
                if (s >= 0)
                begin
                    r.ok  = 1'b1;
                    r.rec = slots[s];
                end
            end
            ACT_WINDOW:
                if (used > 0)
                    r.ok = (t - slots[used-1].paired_at) <= window_val;
            default: ;
        endcase
        r.count = used[3:0];
        awaited.push_back(r);
    endtask

    task automatic compare(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t w;
        table_result_t g;
        if (!rst_n)
        begin
            used      = 0;
            window_val = '0;
            fail_count = 0;
            awaited.delete();
        end
        else
        begin
            if (cfg_wr_en)
                window_val = cfg_wr_data;
            if (m_tvalid && m_tready)
            begin
                g = {m_tdata[0], m_tdata[3:1], m_tdata[51:4], m_tdata[83:52],
                     m_tdata[115:84], m_tdata[131:116], m_tdata[147:132],
                     m_tdata[163:148], m_tdata[171:164], m_tdata[172], m_tdata[176:173]};
                if (awaited.size() == 0)
                begin
                    $error("result with nothing expected");
                    fail_count++;
                end
                else
                begin
                    w = awaited.pop_front();
                    compare("ok", 64'(w.ok), 64'(g.ok));
                    compare("found_slot", 64'(w.found_slot), 64'(g.found_slot));
                    compare("out_dev_addr", 64'(w.rec.dev_addr), 64'(g.rec.dev_addr));
                    compare("out_paired_at", 64'(w.rec.paired_at), 64'(g.rec.paired_at));
                    compare("out_last_seen", 64'(w.rec.last_seen), 64'(g.rec.last_seen));
                    compare("out_vendor", 64'(w.rec.vendor), 64'(g.rec.vendor));
                    compare("out_product", 64'(w.rec.product), 64'(g.rec.product));
                    compare("out_descriptor_len", 64'(w.rec.descriptor_len),
                            64'(g.rec.descriptor_len));
                    compare("out_proto_mode", 64'(w.rec.proto_mode),
                            64'(g.rec.proto_mode));
                    compare("out_reconnect", 64'(w.rec.reconnect), 64'(g.rec.reconnect));
                    compare("entry_count", 64'(w.count), 64'(g.count));
                end
            end
            if (s_tvalid && s_tready)
                apply_item(s_tdata);
        end
    end
endmodule

// ===== sim/testbench.sv =====
// Testbench top: drives items and window settings into the paired device table.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pdt_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [31:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [183:0] m_tdata;
    int           fail_count;
    int           pending;
    int           cycles;
    int           burst_left;
    int           stall_mode;
    logic [47:0]  known_ids[8];

    paired_device_table DUT (.*);

    pdt_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 2);
    end

    function automatic logic [47:0] pick_id();
        if ($urandom_range(0, 3) != 0)
            return known_ids[$urandom_range(0, 7)];
        return 48'({$urandom, $urandom});
    endfunction

    task automatic send_item(action_t act, logic [47:0] id, logic [2:0] idx,
                             logic [31:0] t, logic [15:0] ven, logic [15:0] prod,
                             logic [15:0] dlen, logic [7:0] mode, logic allow);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {allow, mode, dlen, prod, ven, t, idx, id, act};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random(int n);
        logic [3:0] a;
        logic [31:0] t;
        for (int i = 0; i < n; i++)
        begin
            a = ($urandom_range(0, 39) == 0) ? 4'($urandom_range(9, 15)) :
                ($urandom_range(0, 19) == 0) ? ACT_CLEAR : 4'($urandom_range(0, 8));
            if (a == ACT_CLEAR && $urandom_range(0, 1) == 0)
                a = ACT_REMOVE;
            t = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 2000));
            send_item(action_t'(a), pick_id(), 3'($urandom), t, 16'($urandom),
                      16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_window(logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] windows[4];
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b1;
        cycles      = 0;
        burst_left  = 0;
        stall_mode  = 0;
        windows     = '{32'd0, 32'hFFFF_FFFF, 32'd500, 32'($urandom_range(1, 3000))};
        foreach (known_ids[i])
            known_ids[i] = 48'({$urandom, $urandom});
        known_ids[0] = '0;
        known_ids[1] = '1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, fill past full, all actions, extremes
        send_item(ACT_REMOVE, '0, 3'd0, '0, '0, '0, '0, '0, 1'b0);
        send_item(ACT_READ, '0, 3'd0, '0, '0, '0, '0, '0, 1'b0);
        send_item(ACT_CANDIDATE, '0, 3'd0, '0, '0, '0, '0, '0, 1'b0);
        send_item(ACT_WINDOW, '0, 3'd0, '0, '0, '0, '0, '0, 1'b0);
        send_item(ACT_FIND, '1, 3'd0, '0, '0, '0, '0, '0, 1'b0);
        send_item(ACT_RECONNECT, '1, 3'd0, '0, '0, '0, '0, '0, 1'b1);
        for (int i = 0; i < 9; i++)
            send_item(ACT_ADD, known_ids[i % 8], 3'd0, 32'(100 * i), '0, '0, '0, '0, 1'b0);
        send_item(ACT_TOUCH, known_ids[1], 3'd0, '1, '1, '1, '1, '1, 1'b1);
        send_item(ACT_TOUCH, 48'h123456, 3'd0, '1, '1, '1, '1, '1, 1'b1);
        send_item(ACT_READ, '0, 3'd7, '0, '0, '0, '0, '0, 1'b0);
        send_item(ACT_RECONNECT, known_ids[1], 3'd0, '0, '0, '0, '0, '0, 1'b0);
        send_item(ACT_CANDIDATE, '0, 3'd0, '0, '0, '0, '0, '0, 1'b0);
        send_item(ACT_WINDOW, '0, 3'd0, 32'd700, '0, '0, '0, '0, 1'b0);
        send_item(ACT_FIND, known_ids[7], 3'd0, '0, '0, '0, '0, '0, 1'b0);
        send_item(action_t'(4'd15), '1, 3'd7, '1, '1, '1, '1, '1, 1'b1);
        send_item(ACT_CLEAR, '0, 3'd0, '0, '0, '0, '0, '0, 1'b0);
        send_item(ACT_TOUCH, '0, 3'd0, 32'd5, '0, '0, '0, '0, 1'b0);
        send_item(ACT_READ, '0, 3'd0, '0, '0, '0, '0, '0, 1'b0);
        quiesce();

        foreach (windows[w])
        begin
            write_window(windows[w]);
            send_random(370);
            quiesce();
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
